### rtl/rsa_me_pkg.sv
// Shared types, micro-op codes and the microprogram of the modular exponentiation engine.
package rsa_me_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PUB_EXP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRIV_EXP = 2'd2;

   // Microprogram addresses
   localparam int PC_BITS = 4;
   typedef logic [PC_BITS-1:0] pc_type;

   localparam pc_type PC_IDLE   = 4'd0;
   localparam pc_type PC_CHK    = 4'd1;
   localparam pc_type PC_RED    = 4'd2;
   localparam pc_type PC_RED_WB = 4'd3;
   localparam pc_type PC_SQ     = 4'd4;
   localparam pc_type PC_SQ_WB  = 4'd5;
   localparam pc_type PC_MU     = 4'd6;
   localparam pc_type PC_MU_WB  = 4'd7;
   localparam pc_type PC_NEXT   = 4'd8;
   localparam pc_type PC_OUT    = 4'd9;
   localparam pc_type PC_ZERO   = 4'd10;
   localparam pc_type PC_DBL    = 4'd11;
   localparam pc_type PC_ADD    = 4'd12;

   // Datapath micro-operations
   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_SETUP_RED = 4'd1,
      OP_WB_BASE   = 4'd2,
      OP_SETUP_SQ  = 4'd3,
      OP_SETUP_MU  = 4'd4,
      OP_WB_ACC    = 4'd5,
      OP_EXP_SHIFT = 4'd6,
      OP_EMIT      = 4'd7,
      OP_CLR_ACC   = 4'd8,
      OP_MUL_DBL   = 4'd9,
      OP_MUL_ADD   = 4'd10
   } op_type;

   // Branch conditions; a false condition falls through to the next step, except C_LOOP_RET, which returns to the link
   typedef enum logic [2:0] {
      C_NEXT      = 3'd0,
      C_ALWAYS    = 3'd1,
      C_IDLE_WAIT = 3'd2,
      C_MOD_SMALL = 3'd3,
      C_EXP_CLR   = 3'd4,
      C_ECNT_NZ   = 3'd5,
      C_LOOP_RET  = 3'd6
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     call;
      pc_type   target;
   } cword_type;

   // Sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   accept;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic mod_small;
      logic exp_bit;
      logic ecnt_nz;
      logic bcnt_nz;
   } stat_type;

   function automatic cword_type prog_rom(input pc_type pc);
      cword_type cw;
      cw = '{op: OP_NOP, cond: C_ALWAYS, call: 1'b0, target: PC_IDLE};
      unique case (pc)
         PC_IDLE:   cw = '{op: OP_NOP,       cond: C_IDLE_WAIT, call: 1'b0, target: PC_IDLE};
         PC_CHK:    cw = '{op: OP_NOP,       cond: C_MOD_SMALL, call: 1'b0, target: PC_ZERO};
         PC_RED:    cw = '{op: OP_SETUP_RED, cond: C_ALWAYS,    call: 1'b1, target: PC_DBL};
         PC_RED_WB: cw = '{op: OP_WB_BASE,   cond: C_NEXT,      call: 1'b0, target: PC_IDLE};
         PC_SQ:     cw = '{op: OP_SETUP_SQ,  cond: C_ALWAYS,    call: 1'b1, target: PC_DBL};
         PC_SQ_WB:  cw = '{op: OP_WB_ACC,    cond: C_EXP_CLR,   call: 1'b0, target: PC_NEXT};
         PC_MU:     cw = '{op: OP_SETUP_MU,  cond: C_ALWAYS,    call: 1'b1, target: PC_DBL};
         PC_MU_WB:  cw = '{op: OP_WB_ACC,    cond: C_NEXT,      call: 1'b0, target: PC_IDLE};
         PC_NEXT:   cw = '{op: OP_EXP_SHIFT, cond: C_ECNT_NZ,   call: 1'b0, target: PC_SQ};
         PC_OUT:    cw = '{op: OP_EMIT,      cond: C_ALWAYS,    call: 1'b0, target: PC_IDLE};
         PC_ZERO:   cw = '{op: OP_CLR_ACC,   cond: C_ALWAYS,    call: 1'b0, target: PC_OUT};
         PC_DBL:    cw = '{op: OP_MUL_DBL,   cond: C_NEXT,      call: 1'b0, target: PC_IDLE};
         PC_ADD:    cw = '{op: OP_MUL_ADD,   cond: C_LOOP_RET,  call: 1'b0, target: PC_DBL};
         default:   cw = '{op: OP_NOP,       cond: C_ALWAYS,    call: 1'b0, target: PC_IDLE};
      endcase
      return cw;
   endfunction

endpackage

### rtl/rsa_me_seq.sv
// Microcode sequencer: step counter, return link and program ROM.
module rsa_me_seq
   import rsa_me_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy
);

   pc_type    pc_ff, pc_in;
   pc_type    link_ff, link_in;
   pc_type    pc_inc;
   cword_type cw;

   assign cw     = prog_rom(pc_ff);
   assign pc_inc = pc_ff + pc_type'(1);
   assign busy   = (pc_ff != PC_IDLE);

   assign ctrl.op     = cw.op;
   assign ctrl.accept = start && !busy;

   always_comb begin
      pc_in   = pc_inc;
      link_in = link_ff;
      if (cw.call) begin
         pc_in   = cw.target;
         link_in = pc_inc;
      end else begin
         case (cw.cond)
            C_NEXT:      pc_in = pc_inc;
            C_ALWAYS:    pc_in = cw.target;
            C_IDLE_WAIT: pc_in = start ? pc_inc : cw.target;
            C_MOD_SMALL: pc_in = stat.mod_small ? cw.target : pc_inc;
            C_EXP_CLR:   pc_in = stat.exp_bit ? pc_inc : cw.target;
            C_ECNT_NZ:   pc_in = stat.ecnt_nz ? cw.target : pc_inc;
            C_LOOP_RET:  pc_in = stat.bcnt_nz ? cw.target : link_ff;
            default:     pc_in = PC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_IDLE;
         link_ff <= PC_IDLE;
      end else begin
         pc_ff   <= pc_in;
         link_ff <= link_in;
      end
   end

endmodule

### rtl/rsa_me_dp.sv
// Datapath: key registers, exponent shifter and bit-serial modular multiplier.
module rsa_me_dp
   import rsa_me_pkg::*;
#(
   parameter int WORD_BITS = 32
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_type                ctrl,
   output stat_type                stat,
   input  logic                    req_operation,
   input  logic [WORD_BITS-1:0]    req_operand_value,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata,
   output logic                    rsp_valid,
   output logic [WORD_BITS-1:0]    rsp_result_value
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   logic [WORD_BITS-1:0] mod_ff, mod_in;
   logic [WORD_BITS-1:0] pub_ff, pub_in;
   logic [WORD_BITS-1:0] priv_ff, priv_in;
   logic                 sel_ff, sel_in;
   logic [WORD_BITS-1:0] val_ff, val_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [CNT_BITS-1:0]  ecnt_ff, ecnt_in;
   logic [WORD_BITS-1:0] macc_ff, macc_in;
   logic [WORD_BITS-1:0] ma_ff, ma_in;
   logic [WORD_BITS-1:0] mb_ff, mb_in;
   logic [CNT_BITS-1:0]  bcnt_ff, bcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_res_ff, rsp_res_in;

   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS:0]   diff;
   logic [WORD_BITS-1:0] add_res;

   // (macc + addend) mod m, both terms already below m
   assign addend  = (ctrl.op == OP_MUL_DBL) ? macc_ff : ma_ff;
   assign sum     = {1'b0, macc_ff} + {1'b0, addend};
   assign diff    = sum - {1'b0, mod_ff};
   assign add_res = (sum >= {1'b0, mod_ff}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];

   assign stat.mod_small = (mod_ff[WORD_BITS-1:1] == '0);
   assign stat.exp_bit   = exp_ff[WORD_BITS-1];
   assign stat.ecnt_nz   = (ecnt_ff != '0);
   assign stat.bcnt_nz   = (bcnt_ff != '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;

   always_comb begin
      mod_in       = mod_ff;
      pub_in       = pub_ff;
      priv_in      = priv_ff;
      sel_in       = sel_ff;
      val_in       = val_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      ecnt_in      = ecnt_ff;
      macc_in      = macc_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      bcnt_in      = bcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_res_in   = rsp_res_ff;

      if (csr_we) begin
         case (csr_index)
            REG_MODULUS:  mod_in  = csr_wdata;
            REG_PUB_EXP:  pub_in  = csr_wdata;
            REG_PRIV_EXP: priv_in = csr_wdata;
            default:      ;
         endcase
      end

      if (ctrl.accept) begin
         sel_in = req_operation;
         val_in = req_operand_value;
      end

      unique case (ctrl.op)
         OP_NOP: ;
         OP_SETUP_RED: begin
            // reduce the operand: multiply one by it
            ma_in   = WORD_BITS'(1);
            mb_in   = val_ff;
            macc_in = '0;
            bcnt_in = CNT_LAST;
         end
         OP_WB_BASE: begin
            base_in = macc_ff;
            acc_in  = WORD_BITS'(1);
            exp_in  = sel_ff ? priv_ff : pub_ff;
            ecnt_in = CNT_LAST;
         end
         OP_SETUP_SQ: begin
            ma_in   = acc_ff;
            mb_in   = acc_ff;
            macc_in = '0;
            bcnt_in = CNT_LAST;
         end
         OP_SETUP_MU: begin
            ma_in   = base_ff;
            mb_in   = acc_ff;
            macc_in = '0;
            bcnt_in = CNT_LAST;
         end
         OP_WB_ACC: acc_in = macc_ff;
         OP_EXP_SHIFT: begin
            exp_in  = {exp_ff[WORD_BITS-2:0], 1'b0};
            ecnt_in = ecnt_ff - CNT_BITS'(1);
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = acc_ff;
         end
         OP_CLR_ACC: acc_in = '0;
         OP_MUL_DBL: macc_in = add_res;
         OP_MUL_ADD: begin
            if (mb_ff[WORD_BITS-1]) begin
               macc_in = add_res;
            end
            mb_in   = {mb_ff[WORD_BITS-2:0], 1'b0};
            bcnt_in = bcnt_ff - CNT_BITS'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff       <= WORD_BITS'(2);
         pub_ff       <= WORD_BITS'(1);
         priv_ff      <= WORD_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_ff       <= mod_in;
         pub_ff       <= pub_in;
         priv_ff      <= priv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff     <= sel_in;
      val_ff     <= val_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      exp_ff     <= exp_in;
      ecnt_ff    <= ecnt_in;
      macc_ff    <= macc_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      bcnt_ff    <= bcnt_in;
      rsp_res_ff <= rsp_res_in;
   end

`ifndef SYNTH
   a_result_below_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !stat.mod_small |-> rsp_res_ff < mod_ff)
      else $error("result not reduced below modulus");
`endif

endmodule

### rtl/rsa_modular_exponentiation.sv
// Top level of the RSA modular exponentiation engine.
// Usage:
//   Write the modulus, the public exponent and the private exponent through the
//   csr_ channel (index 0, 1, 2; other indexes are dropped). csr_ready is always
//   high; write keys only while the engine is idle.
//   Pulse start with req_operation (0 encrypt, 1 decrypt) and req_operand_value
//   while busy is low; the item is taken at that edge and busy rises.
//   The result item appears on rsp_result_value, marked by rsp_valid for exactly
//   one cycle, in the same cycle as busy falls. The receiver cannot stall it.
// Sequence:
//   The operand is first reduced by one bit-serial modular multiply, then each of
//   the WORD_BITS exponent bits costs a square and, for a set bit, a multiply.
//   Each multiply runs in the shared add-and-reduce unit, between a setup step
//   and a writeback step. A modulus below two answers zero. One item is in
//   flight at a time.
// Reset: synchronous; keys return to modulus 2, both exponents 1, no item held.
module rsa_modular_exponentiation
   import rsa_me_pkg::*;
#(
   parameter int WORD_BITS = 32
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_operation,
   input  logic [WORD_BITS-1:0]    req_operand_value,
   output logic                    rsp_valid,
   output logic [WORD_BITS-1:0]    rsp_result_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata
);

   ctrl_type ctrl;
   stat_type stat;
   logic     csr_we;

   // user must change keys only between items (unenforced); writes always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // step counter, link register and microprogram ROM
   rsa_me_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // keys, exponent shifter and the add-and-reduce multiplier
   rsa_me_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_operand_value (req_operand_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value)
   );

`ifndef SYNTH
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_result_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the RSA modular exponentiation engine.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rsa_me_pkg::*;

   localparam int WORD_BITS    = 32;
   localparam int RANDOM_ITEMS = 1850;
   // The worst item and the longest sender gap both stay well below this limit;
   // no correct run goes anywhere near this many cycles without a handshake.
   localparam int IDLE_LIMIT   = 40000;
   localparam int TAIL_CYCLES  = 64;
   localparam int MAX_REPORTS  = 10;

   // Index 3 is outside the register map and must be dropped by the engine
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE = 2'd3;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;

   // One outstanding item: what was sent and the residue it must produce
   typedef struct {
      logic     mode;
      word_type operand;
      word_type residue;
   } residue_rec_type;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic                    req_operation     = 1'b0;
   word_type                req_operand_value = '0;
   logic                    rsp_valid;
   word_type                rsp_result_value;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index         = '0;
   word_type                csr_wdata         = '0;

   // Key copy kept in step with every register write
   word_type key_modulus;
   word_type key_public;
   word_type key_private;

   residue_rec_type pending_residues[$];
   int              mismatch_count = 0;
   // 0: no sender gaps between items, 1: mix of short and long sender gaps
   int              gap_style      = 1;

   rsa_modular_exponentiation #(
      .WORD_BITS(WORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_operand_value(req_operand_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Operand to the selected exponent modulo the modulus, by square-and-multiply.
   // Products of two residues below 2^32 fit in 64 bits, so a plain % is exact.
   function automatic word_type modexp_predict(input logic mode, input word_type operand);
      logic [63:0] m;
      logic [63:0] base;
      logic [63:0] acc;
      word_type    expo;
      int          i;
      m    = 64'(key_modulus);
      expo = (mode == MODE_DECRYPT) ? key_private : key_public;
      // A modulus below two answers zero outright
      if (m < 64'd2)
         return '0;
      base = 64'(operand) % m;
      acc  = 64'd1;
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (expo[i])
            acc = (acc * base) % m;
      end
      return acc[WORD_BITS-1:0];
   endfunction

   // Mostly real moduli, some tiny ones, the all-ones word and a few below range
   function automatic word_type pick_modulus();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         return word_type'($urandom_range(0, 1));
      if (roll < 24)
         return word_type'($urandom_range(2, 255));
      if (roll < 40)
         return word_type'($urandom) | 32'h8000_0000;
      if (roll < 45)
         return '1;
      return word_type'($urandom_range(2, 32'hFFFF_FFFF));
   endfunction

   function automatic word_type pick_exponent();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return '0;
      if (roll < 20)
         return word_type'(1);
      if (roll < 30)
         return '1;
      if (roll < 50)
         return word_type'($urandom_range(2, 65537));
      return word_type'($urandom);
   endfunction

   // Operands: zero, all ones, exact multiples of the modulus, in-range words
   // and full 32-bit words that need reducing first
   function automatic word_type pick_operand();
      logic [63:0] m;
      word_type    k;
      int          roll;
      m    = 64'(key_modulus);
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return '0;
      if (roll < 14)
         return '1;
      if (roll < 24 && m >= 64'd2) begin
         k = word_type'($urandom_range(0, word_type'(64'hFFFF_FFFF / m)));
         return word_type'(64'(k) * m);
      end
      if (roll < 50 && m >= 64'd2)
         return word_type'(64'($urandom) % m);
      return word_type'($urandom);
   endfunction

   // Write one register; mirror it in the key copy once the handshake completes
   task automatic write_key(input logic [CSR_IDX_BITS-1:0] idx, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MODULUS:  key_modulus = data;
         REG_PUB_EXP:  key_public  = data;
         REG_PRIV_EXP: key_private = data;
         default: ;
      endcase
      // Step past this edge so the next write never raises valid in the same step
      @(posedge clock);
   endtask

   // Hold off until every outstanding item has produced its result
   task automatic wait_idle();
      while (pending_residues.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic load_keys(input word_type modulus_val, input word_type pub_val,
                            input word_type priv_val);
      wait_idle();
      write_key(REG_MODULUS, modulus_val);
      write_key(REG_PUB_EXP, pub_val);
      write_key(REG_PRIV_EXP, priv_val);
   endtask

   // Send one item and queue its predicted residue at the accepting edge
   task automatic send_item(input logic mode, input word_type operand);
      int              roll;
      residue_rec_type rec;
      // Wait for the next edge first: start never drops and rises in the same step,
      // and busy is already high here after the previous accept
      @(posedge clock);
      if (gap_style != 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            // Land start just around the edge where the result comes out
            while (busy)
               @(posedge clock);
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end else if (roll < 40) begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else if (roll < 44) begin
            // Long gap: leave the engine idle for a while
            repeat ($urandom_range(1000, 8000)) @(posedge clock);
         end
      end
      start             <= 1'b1;
      req_operation     <= mode;
      req_operand_value <= operand;
      do @(posedge clock); while (busy);
      start       <= 1'b0;
      rec.mode    = mode;
      rec.operand = operand;
      rec.residue = modexp_predict(mode, operand);
      pending_residues.push_back(rec);
   endtask

   // Compare every result item against the oldest prediction
   always @(posedge clock) begin
      residue_rec_type rec;
      if (!reset && rsp_valid) begin
         if (pending_residues.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: result item %h with no item outstanding",
                        $realtime, rsp_result_value);
            mismatch_count++;
         end else begin
            rec = pending_residues.pop_front();
            if (rsp_result_value !== rec.residue) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: mode %0b operand %h: expected %h, got %h",
                           $realtime, rec.mode, rec.operand, rec.residue,
                           rsp_result_value);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: drop the run when no handshake of any kind happens for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog expired, nothing accepted for %0d cycles",
               $realtime, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Reset values: modulus 2 and both exponents 1, so every result is operand mod 2
   task automatic test_reset_keys();
      gap_style = 1;
      send_item(MODE_ENCRYPT, '0);
      send_item(MODE_DECRYPT, word_type'(1));
      send_item(MODE_ENCRYPT, '1);
      send_item(MODE_DECRYPT, 32'hAAAA_5555);
   endtask

   // A zero exponent gives 1, including zero to the zero
   task automatic test_zero_exponent();
      gap_style = 1;
      load_keys(word_type'(1000003), '0, '0);
      send_item(MODE_ENCRYPT, word_type'(12345));
      send_item(MODE_DECRYPT, '1);
      send_item(MODE_ENCRYPT, '0);
   endtask

   // Operands at or above the modulus reduce first; multiples give zero, not n
   task automatic test_operand_reduction();
      gap_style = 1;
      load_keys(word_type'(1000003), word_type'(65537), word_type'(3));
      send_item(MODE_ENCRYPT, word_type'(1000003));
      send_item(MODE_DECRYPT, word_type'(2000006));
      send_item(MODE_ENCRYPT, word_type'(1000004));
      send_item(MODE_DECRYPT, '1);
      send_item(MODE_ENCRYPT, word_type'(1000002));
   endtask

   // Modulus zero and one answer zero; a write to the spare index is dropped
   task automatic test_small_modulus();
      gap_style = 1;
      load_keys('0, word_type'(5), word_type'(7));
      send_item(MODE_ENCRYPT, word_type'(9));
      send_item(MODE_DECRYPT, '1);
      wait_idle();
      write_key(REG_MODULUS, word_type'(1));
      write_key(REG_SPARE, '1);
      send_item(MODE_ENCRYPT, '1);
      send_item(MODE_DECRYPT, '0);
   endtask

   // All-ones modulus and exponents, then a large prime modulus
   task automatic test_key_extremes();
      gap_style = 1;
      load_keys('1, '1, '1);
      send_item(MODE_ENCRYPT, '1);
      send_item(MODE_DECRYPT, 32'hFFFF_FFFE);
      send_item(MODE_ENCRYPT, word_type'(2));
      load_keys(32'hFFFF_FFFB, 32'h8000_0001, word_type'(1));
      send_item(MODE_ENCRYPT, 32'h7FFF_FFFF);
      send_item(MODE_DECRYPT, 32'h8000_0000);
   endtask

   // Phases of random items, each under a fresh random key set. Every phase
   // starts by pausing the sender until all results are in, then rewrites keys.
   task automatic test_random_traffic();
      int remaining;
      int phase_len;
      remaining = RANDOM_ITEMS;
      while (remaining > 0) begin
         phase_len = $urandom_range(20, 90);
         if (phase_len > remaining)
            phase_len = remaining;
         wait_idle();
         if ($urandom_range(0, 3) == 0)
            write_key(REG_SPARE, word_type'($urandom));
         load_keys(pick_modulus(), pick_exponent(), pick_exponent());
         // About one phase in four runs back to back with no sender gaps
         gap_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
         repeat (phase_len)
            send_item(logic'($urandom_range(0, 1)), pick_operand());
         remaining -= phase_len;
      end
   endtask

   initial begin
      key_modulus = word_type'(2);
      key_public  = word_type'(1);
      key_private = word_type'(1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_keys();
      test_zero_exponent();
      test_operand_reduction();
      test_small_modulus();
      test_key_extremes();
      test_random_traffic();

      // Drain, then give any stray result a chance to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
rtl/rsa_me_pkg.sv
rtl/rsa_me_seq.sv
rtl/rsa_me_dp.sv
rtl/rsa_modular_exponentiation.sv
tb/tb_top.sv
